// ===== hw/rtl/allpass_chain_filter_core_defines.svh =====
// Assertion macros for the allpass chain filter core.
// Used by the top level only; no other dependencies.
`ifndef ALLPASS_CHAIN_FILTER_CORE_DEFINES_SVH
`define ALLPASS_CHAIN_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on aclk, held off while aresetn is low.
`define APCF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property on aclk, also during reset.
`define APCF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define APCF_ASSERT(label, prop, msg)
`define APCF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hw/rtl/apcf_pkg.sv =====
// Shared types and constants of the allpass chain filter core.
// No dependencies; imported by every module of the block.
`default_nettype none
package apcf_pkg;

    localparam int MAX_STAGES = 2048;
    localparam int SAMPLE_W   = 24;
    localparam int CFG_W      = 12;
    localparam int IDX_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int COUNT_W    = $clog2(MAX_STAGES + 1);
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int PROD_W     = 2 * SAMPLE_W + 1;
    localparam int Q_W        = PROD_W - SAMPLE_W + 1;
    localparam int SUM_W      = Q_W + 1;
    localparam int MEM_W      = 2 * SAMPLE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } apcf_state_t;

    typedef struct packed {
        logic             start;     // latch new sample and coefficient
        logic             rd_first;  // read stage 0 instead of the next stage
        logic [IDX_W-1:0] stage_idx; // stage being worked on
        logic             mul_en;    // form difference and product
        logic             add_en;    // finish stage, write back its stores
        logic             load_out;  // move final stage output to the result register
    } apcf_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/apcf_datapath.sv =====
// Datapath of the allpass chain filter: stage store memory, multiply-add, output register.
// Depends on apcf_pkg; driven by apcf_ctrl through apcf_cmd_t.
`default_nettype none
module apcf_datapath
    import apcf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire apcf_cmd_t                  cmd,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_in,
    input  wire logic signed [SAMPLE_W-1:0] s_coefficient,
    output logic signed [SAMPLE_W-1:0]      m_sample_out
);

    localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0]   ROUND_C = PROD_W'(1) <<< (SAMPLE_W - 2);

    // {previous input, previous output} per stage
    logic [MEM_W-1:0] mem [MAX_STAGES];
    logic [MEM_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [COUNT_W-1:0]       fill_reg, fill_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] a_reg, a_next;
    logic signed [SAMPLE_W-1:0] x1_reg, x1_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] out_reg, out_next;

    logic                       entry_valid;
    logic signed [SAMPLE_W-1:0] y1_val;
    logic signed [PROD_W-1:0]   a_ext, d_ext;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [Q_W-1:0]      q;
    logic signed [SUM_W-1:0]    y_wide;
    logic signed [SAMPLE_W-1:0] y_sat;

    assign rd_addr = cmd.rd_first ? '0 : IDX_W'(cmd.stage_idx + IDX_W'(1));

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.add_en) begin
            mem[cmd.stage_idx] <= {x_reg, y_sat};
        end
    end

    // Entries at or above the fill count were never written and read as zero.
    assign entry_valid = COUNT_W'(cmd.stage_idx) < fill_reg;
    assign y1_val      = entry_valid ? $signed(rd_data_reg[SAMPLE_W-1:0]) : '0;
    assign diff        = DIFF_W'(x_reg) - DIFF_W'(y1_val);
    assign a_ext       = PROD_W'(a_reg);
    assign d_ext       = PROD_W'(diff);
    assign prod_next   = cmd.mul_en ? a_ext * d_ext : prod_reg;
    assign x1_next     = cmd.mul_en
                         ? (entry_valid ? $signed(rd_data_reg[MEM_W-1:SAMPLE_W]) : '0)
                         : x1_reg;

    assign rounded = prod_reg + ROUND_C;
    assign q       = rounded[PROD_W-1:SAMPLE_W-1];
    assign y_wide  = SUM_W'(x1_reg) + SUM_W'(q);

    always_comb begin
        if (y_wide[SUM_W-1:SAMPLE_W-1] == '0 || y_wide[SUM_W-1:SAMPLE_W-1] == '1) begin
            y_sat = y_wide[SAMPLE_W-1:0];
        end else begin
            y_sat = y_wide[SUM_W-1] ? SMIN : SMAX;
        end
    end

    always_comb begin
        x_next    = x_reg;
        a_next    = a_reg;
        out_next  = out_reg;
        fill_next = fill_reg;
        if (cmd.start) begin
            x_next = s_sample_in;
            a_next = s_coefficient;
        end
        if (cmd.add_en) begin
            x_next = y_sat;
            if (COUNT_W'(cmd.stage_idx) == fill_reg) begin
                fill_next = fill_reg + COUNT_W'(1);
            end
        end
        if (cmd.load_out) begin
            out_next = x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
        x_reg    <= x_next;
        a_reg    <= a_next;
        x1_reg   <= x1_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign m_sample_out = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/apcf_ctrl.sv =====
// Controller of the allpass chain filter: handshakes, stage sequencing, stage count register.
// Depends on apcf_pkg; drives apcf_datapath through apcf_cmd_t.
`default_nettype none
module apcf_ctrl
    import apcf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    output apcf_cmd_t             cmd
);

    apcf_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   stage_reg, stage_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [CFG_W-1:0]   cfg_reg, cfg_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] count_clamped;
    logic               is_last;
    logic               out_free;

    assign is_last  = stage_reg == last_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Clamp the stage count to 1..MAX_STAGES.
    always_comb begin
        if (cfg_reg == '0) begin
            count_clamped = COUNT_W'(1);
        end else if (int'(cfg_reg) > MAX_STAGES) begin
            count_clamped = COUNT_W'(MAX_STAGES);
        end else begin
            count_clamped = COUNT_W'(cfg_reg);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD: begin
                state_next = is_last ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready       = 1'b0;
        cmd.start     = 1'b0;
        cmd.rd_first  = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.add_en    = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.stage_idx = stage_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.start    = s_valid;
                cmd.rd_first = 1'b1;
            end
            ST_MUL:  cmd.mul_en = 1'b1;
            ST_ADD:  cmd.add_en = 1'b1;
            ST_DONE: cmd.load_out = out_free;
            default: s_ready = 1'b0;
        endcase
    end

    always_comb begin
        stage_next   = stage_reg;
        last_next    = last_reg;
        cfg_next     = cfg_valid ? cfg_data : cfg_reg;
        m_valid_next = m_valid_reg;
        if (cmd.start) begin
            stage_next = '0;
            last_next  = IDX_W'(count_clamped - COUNT_W'(1));
        end else if (cmd.add_en && !is_last) begin
            stage_next = stage_reg + IDX_W'(1);
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stage_reg   <= '0;
            last_reg    <= '0;
            cfg_reg     <= CFG_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stage_reg   <= stage_next;
            last_reg    <= last_next;
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/allpass_chain_filter_core.sv =====
// Top level of the allpass chain filter core: controller plus datapath.
// Depends on apcf_pkg, apcf_ctrl, apcf_datapath and allpass_chain_filter_core_defines.svh.
// Usage:
//   Input channel (s_valid/s_ready): one transfer carries a signed Q1.23 sample and
//   a signed Q1.23 allpass coefficient. Result channel (m_valid/m_ready): one
//   transfer per input, the saturated output of the last active stage.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes the stage count; always
//   ready. Write it only while the core is idle. Zero acts as one stage, values
//   above 2048 act as 2048.
//   Sequencing: the core works on one item at a time and takes the next input
//   only after returning to idle. Each stage is a multiply by the coefficient,
//   then the rounding add, saturation and write-back of the stage store, and
//   the next stage's input is this stage's output. After the last stage the
//   done state loads the result register and sets m_valid with it.
//   Reset (aresetn low, synchronous) clears the controller, sets the stage count
//   to one and empties the stage store; the core takes items right away, with
//   stores never written reading as zero.
//   Stall: the result register holds the finished output while m_ready is low;
//   the core still takes and works on the next item, and holds its result
//   until the register drains.
`default_nettype none
`include "allpass_chain_filter_core_defines.svh"
module allpass_chain_filter_core
    import apcf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_in,
    input  wire logic signed [SAMPLE_W-1:0] s_coefficient,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_sample_out,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_W-1:0]           cfg_data
);

    apcf_cmd_t cmd;

    // Sequence stages, own the handshakes and the stage count register.
    apcf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd)
    );

    // Hold the stage stores and run the multiply-add for one stage at a time.
    apcf_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_sample_in   (s_sample_in),
        .s_coefficient (s_coefficient),
        .m_sample_out  (m_sample_out)
    );

    // Go busy after each input transfer.
    `APCF_ASSERT(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready, "input taken while busy")
    // Never overwrite a result that waits for the receiver.
    `APCF_ASSERT(a_no_overwrite, cmd.load_out |-> (!m_valid || m_ready), "pending result overwritten")
    // A loaded result is offered on the next cycle.
    `APCF_ASSERT(a_load_shows, cmd.load_out |=> m_valid, "loaded result not offered")
    // Write-back alternates with the multiply step.
    `APCF_ASSERT_ALWAYS(a_wb_alternate, cmd.add_en |=> !cmd.add_en, "back-to-back write-back")

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for allpass_chain_filter_core: directed rows, then random phases.
// Each phase sets the stage count, then streams samples with random gaps and stalls, or with none in some phases.
// Depends on apcf_pkg and the core RTL only.
module tb_top;
    import apcf_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint SAT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;
    localparam int     PHASES  = 14;

    typedef enum logic {ROW_SAMPLE, ROW_STAGES} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_W-1:0]           stages;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] a;
        logic                       checked;
        logic signed [SAMPLE_W-1:0] typed_out;
    } stim_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic signed [SAMPLE_W-1:0] s_coefficient;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_W-1:0]           cfg_data;

    // Shadow of the stage count and of every stage's history.
    logic [CFG_W-1:0]           stage_count_shadow;
    logic signed [SAMPLE_W-1:0] stage_last_in  [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] stage_last_out [MAX_STAGES];

    logic signed [SAMPLE_W-1:0] pending_outputs [$];
    stim_row_t                  directed_rows [$];
    int                         mismatch_count;
    logic                       no_idle;

    allpass_chain_filter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .s_coefficient (s_coefficient),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Run one sample through the active stages, updating the shadow history.
    // Each stage: y = x1 + round(a * (x - y1)), rounded half up, then saturated.
    function automatic logic signed [SAMPLE_W-1:0] run_cascade(
        input logic signed [SAMPLE_W-1:0] sample,
        input logic signed [SAMPLE_W-1:0] coef
    );
        longint x;
        longint y;
        longint prod;
        int     active;
        active = (stage_count_shadow == 0) ? 1 :
                 (stage_count_shadow > MAX_STAGES) ? MAX_STAGES : int'(stage_count_shadow);
        x = sample;
        y = x;
        for (int k = 0; k < active; k++) begin
            prod = longint'(coef) * (x - longint'(stage_last_out[k]));
            y = longint'(stage_last_in[k])
                + ((prod + (longint'(1) <<< (SAMPLE_W - 2))) >>> (SAMPLE_W - 1));
            if (y > SAT_MAX)
                y = SAT_MAX;
            else if (y < SAT_MIN)
                y = SAT_MIN;
            stage_last_in[k]  = SAMPLE_W'(x);
            stage_last_out[k] = SAMPLE_W'(y);
            x = y;
        end
        return SAMPLE_W'(y);
    endfunction

    // Mix extremes and tiny values into the random fields to reach saturation.
    function automatic logic signed [SAMPLE_W-1:0] rand_field();
        case ($urandom_range(0, 9))
            0: return FULL_POS;
            1: return FULL_NEG;
            2: return SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(3);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic void add_sample(input logic signed [SAMPLE_W-1:0] x,
                                       input logic signed [SAMPLE_W-1:0] a);
        directed_rows.push_back({ROW_SAMPLE, CFG_W'(0), x, a, 1'b0, SAMPLE_W'(0)});
    endfunction

    function automatic void add_checked(input logic signed [SAMPLE_W-1:0] x,
                                        input logic signed [SAMPLE_W-1:0] a,
                                        input logic signed [SAMPLE_W-1:0] y);
        directed_rows.push_back({ROW_SAMPLE, CFG_W'(0), x, a, 1'b1, y});
    endfunction

    function automatic void add_stages(input logic [CFG_W-1:0] v);
        directed_rows.push_back({ROW_STAGES, v, SAMPLE_W'(0), SAMPLE_W'(0), 1'b0, SAMPLE_W'(0)});
    endfunction

    // Entered and left at a falling edge. Hold valid across back-to-back transfers.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                               input logic signed [SAMPLE_W-1:0] a,
                               input logic                       use_typed,
                               input logic signed [SAMPLE_W-1:0] typed_out);
        int                         gap;
        logic signed [SAMPLE_W-1:0] predicted;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_sample_in   = x;
        s_coefficient = a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = run_cascade(x, a);
        pending_outputs.push_back(use_typed ? typed_out : predicted);
        @(negedge aclk);
    endtask

    // Drain the core, then write the stage count while it is idle.
    task automatic write_stage_count(input logic [CFG_W-1:0] v);
        s_valid = 1'b0;
        while (pending_outputs.size() != 0) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        stage_count_shadow = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Result side: check each transfer, then draw a stall for the next one.
    initial begin
        int                         hold;
        logic signed [SAMPLE_W-1:0] want;
        hold    = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_outputs.size() == 0) begin
                    $display("%0t: sample_out expected none, got %0d", $time, m_sample_out);
                    mismatch_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (m_sample_out !== want) begin
                        $display("%0t: sample_out expected %0d, got %0d",
                                 $time, want, m_sample_out);
                        mismatch_count++;
                    end
                end
                hold = no_idle ? 0 : $urandom_range(0, 6);
            end
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin
        int cfg_pick;
        int n_items;
        s_valid            = 1'b0;
        s_sample_in        = '0;
        s_coefficient      = '0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        no_idle            = 1'b0;
        mismatch_count     = 0;
        stage_count_shadow = CFG_W'(1);
        for (int k = 0; k < MAX_STAGES; k++) begin
            stage_last_in[k]  = '0;
            stage_last_out[k] = '0;
        end
        aresetn = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // One stage from reset: with a zero coefficient the output is the previous
        // input; minus one times full-scale negative saturates high.
        add_checked(SAMPLE_W'(0), SAMPLE_W'(0), SAMPLE_W'(0));
        add_checked(FULL_NEG, FULL_NEG, FULL_POS);
        add_checked(FULL_POS, SAMPLE_W'(0), FULL_NEG);
        add_checked(SAMPLE_W'(0), SAMPLE_W'(0), FULL_POS);
        add_sample(FULL_POS, FULL_POS);
        add_sample(FULL_NEG, FULL_POS);
        add_sample(FULL_POS, FULL_NEG);
        add_sample(-SAMPLE_W'(1), SAMPLE_W'(1));
        add_sample(SAMPLE_W'(1), -SAMPLE_W'(1));
        // Zero stages acts as one.
        add_stages(CFG_W'(0));
        add_sample(24'sh555555, 24'shAAAAAA);
        add_sample(24'shAAAAAA, 24'sh555555);
        // All-ones count clamps to the maximum depth.
        add_stages({CFG_W{1'b1}});
        add_sample(FULL_POS, FULL_POS);
        add_sample(FULL_NEG, FULL_NEG);
        add_stages(CFG_W'(3));
        add_sample(24'sh400000, 24'sh400000);
        add_sample(-24'sh400000, -24'sh400000);
        add_stages(CFG_W'(MAX_STAGES));
        add_sample(SAMPLE_W'(1000), SAMPLE_W'(7000000));
        // Drop to one stage, then raise again: the idle stages resume their history.
        add_stages(CFG_W'(1));
        add_sample(SAMPLE_W'(12345), -SAMPLE_W'(3000000));
        add_stages(CFG_W'(5));
        add_sample(-SAMPLE_W'(77), SAMPLE_W'(8000000));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_STAGES)
                write_stage_count(directed_rows[i].stages);
            else
                send_sample(directed_rows[i].x, directed_rows[i].a,
                            directed_rows[i].checked, directed_rows[i].typed_out);
        end

        // Mostly shallow cascades; a few deep ones, some past the clamp.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 7)
                3: begin
                    cfg_pick = MAX_STAGES + $urandom_range(0, 2047);
                    n_items  = 4;
                end
                6: begin
                    cfg_pick = $urandom_range(13, 300);
                    n_items  = 15;
                end
                default: begin
                    cfg_pick = $urandom_range(0, 12);
                    n_items  = 23;
                end
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            write_stage_count(CFG_W'(cfg_pick));
            repeat (n_items) send_sample(rand_field(), rand_field(), 1'b0, SAMPLE_W'(0));
        end

        s_valid = 1'b0;
        while (pending_outputs.size() != 0) @(negedge aclk);
        // Catch any stray result after the last one expected.
        repeat (2 * MAX_STAGES + 8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== allpass_chain_filter_core.f =====
+incdir+hw/rtl
hw/rtl/apcf_pkg.sv
hw/rtl/apcf_datapath.sv
hw/rtl/apcf_ctrl.sv
hw/rtl/allpass_chain_filter_core.sv
tb/sv/tb_top.sv
